// ----- rtl/aop_pkg.sv -----
// Shared types, widths and helper functions for the box overlap push-side block.
package aop_pkg;

  // Coordinate and scale widths
  localparam int COORD_WIDTH = 32;
  localparam int SCALE_WIDTH = 16;
  localparam int FRAC_SHIFT  = 8;
  localparam int PUSH_W      = 32;

  // Derived datapath widths: product, scaled extent, bound, difference, gap
  localparam int EXT_W   = COORD_WIDTH + SCALE_WIDTH;
  localparam int SEXT_W  = EXT_W - FRAC_SHIFT;
  localparam int BOUND_W = SEXT_W + 1;
  localparam int DIFF_W  = BOUND_W + 1;
  localparam int GAP_W   = DIFF_W;
  localparam int WIDE_W  = (DIFF_W > PUSH_W) ? DIFF_W : PUSH_W + 1;

  // Axis codes; the last one marks an item to drop
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    axis_t                          axis;
    logic signed [COORD_WIDTH-1:0]  a_last_pos;
    logic signed [COORD_WIDTH-1:0]  a_now_pos;
    logic signed [COORD_WIDTH-1:0]  a_min;
    logic signed [COORD_WIDTH-1:0]  a_max;
    logic        [SCALE_WIDTH-1:0]  a_scale;
    logic signed [COORD_WIDTH-1:0]  b_last_pos;
    logic signed [COORD_WIDTH-1:0]  b_now_pos;
    logic signed [COORD_WIDTH-1:0]  b_min;
    logic signed [COORD_WIDTH-1:0]  b_max;
    logic        [SCALE_WIDTH-1:0]  b_scale;
    logic                           want_push;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [PUSH_W-1:0] push_x;
    logic signed [PUSH_W-1:0] push_y;
    logic signed [PUSH_W-1:0] push_z;
  } out_item_t;

  // Per-axis figures handed from the datapath to the running-minimum stage
  typedef struct packed {
    axis_t                    axis;
    logic                     want_push;
    logic                     ov;
    logic [GAP_W-1:0]         gap_hi;
    logic [GAP_W-1:0]         gap_lo;
    logic signed [PUSH_W-1:0] push_hi;
    logic signed [PUSH_W-1:0] push_lo;
  } axis_res_t;

  // Saturation limits at the output width
  localparam logic signed [WIDE_W-1:0] PUSH_HI =
    WIDE_W'(signed'({1'b0, {(PUSH_W-1){1'b1}}}));
  localparam logic signed [WIDE_W-1:0] PUSH_LO =
    WIDE_W'(signed'({1'b1, {(PUSH_W-1){1'b0}}}));

  // Magnitude of a signed difference
  function automatic logic [GAP_W-1:0] gap_mag(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = -d;
    return d[DIFF_W-1] ? GAP_W'(n) : GAP_W'(d);
  endfunction

  // Clamp a signed difference to the output width
  function automatic logic signed [PUSH_W-1:0] sat_push(
    input logic signed [DIFF_W-1:0] d
  );
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(d);
    if (w > PUSH_HI) begin
      return PUSH_HI[PUSH_W-1:0];
    end else if (w < PUSH_LO) begin
      return PUSH_LO[PUSH_W-1:0];
    end
    return w[PUSH_W-1:0];
  endfunction

endpackage

// ----- rtl/aop_axis_pipe.sv -----
// Per-axis datapath: scaled extents, bounds, differences, gaps and penetrations.
module aop_axis_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aop_pkg::in_item_t   in_data,
  output logic                res_valid,
  input  logic                res_take,
  output aop_pkg::axis_res_t  res_data
);

  localparam int SEXT_W  = aop_pkg::SEXT_W;
  localparam int BOUND_W = aop_pkg::BOUND_W;
  localparam int DIFF_W  = aop_pkg::DIFF_W;
  localparam int EXT_W   = aop_pkg::EXT_W;
  localparam int PAD_W   = EXT_W - aop_pkg::SCALE_WIDTH;
  localparam int CW      = aop_pkg::COORD_WIDTH;

  // Stage valids and per-stage readiness
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1: input register
  aop_pkg::in_item_t s1_r;

  // Stage 2: scaled extents and positions
  aop_pkg::axis_t           ax2_r;
  logic                     want2_r;
  logic signed [CW-1:0]     alp2_r, anp2_r, blp2_r, bnp2_r;
  logic signed [SEXT_W-1:0] alo2_r, ahi2_r, blo2_r, bhi2_r;
  logic signed [EXT_W-1:0]  p_alo_nxt, p_ahi_nxt, p_blo_nxt, p_bhi_nxt;

  // Stage 3: bounds at previous and current positions
  aop_pkg::axis_t            ax3_r;
  logic                      want3_r;
  logic signed [BOUND_W-1:0] alo_l3_r, ahi_l3_r, blo_l3_r, bhi_l3_r;
  logic signed [BOUND_W-1:0] alo_n3_r, ahi_n3_r, blo_n3_r, bhi_n3_r;

  // Stage 4: differences
  aop_pkg::axis_t           ax4_r;
  logic                     want4_r;
  logic signed [DIFF_W-1:0] gd_hi4_r, gd_lo4_r, pd_hi4_r, pd_lo4_r;

  // Stage 5: result figures
  aop_pkg::axis_res_t res5_r;
  aop_pkg::axis_res_t res5_nxt;

  // Close up bubbles: a stage loads when empty or when it hands on
  assign rdy5     = !v5_r || res_take;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // Advance valids; drop items with no axis at the input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid && (in_data.axis != aop_pkg::AXIS_NONE);
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  // Scale the local extents (Q16.16 times Q8.8, floored back to Q16.16)
  always_comb begin
    p_alo_nxt = EXT_W'(s1_r.a_min) * $signed({{PAD_W{1'b0}}, s1_r.a_scale});
    p_ahi_nxt = EXT_W'(s1_r.a_max) * $signed({{PAD_W{1'b0}}, s1_r.a_scale});
    p_blo_nxt = EXT_W'(s1_r.b_min) * $signed({{PAD_W{1'b0}}, s1_r.b_scale});
    p_bhi_nxt = EXT_W'(s1_r.b_max) * $signed({{PAD_W{1'b0}}, s1_r.b_scale});
  end

  // Form gaps, penetrations and the strict overlap flag
  always_comb begin
    res5_nxt.axis      = ax4_r;
    res5_nxt.want_push = want4_r;
    res5_nxt.ov        = (!pd_hi4_r[DIFF_W-1] && (|pd_hi4_r)) && pd_lo4_r[DIFF_W-1];
    res5_nxt.gap_hi    = aop_pkg::gap_mag(gd_hi4_r);
    res5_nxt.gap_lo    = aop_pkg::gap_mag(gd_lo4_r);
    res5_nxt.push_hi   = aop_pkg::sat_push(pd_hi4_r);
    res5_nxt.push_lo   = aop_pkg::sat_push(pd_lo4_r);
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= in_data;
    end
    if (rdy2) begin
      ax2_r   <= s1_r.axis;
      want2_r <= s1_r.want_push;
      alp2_r  <= s1_r.a_last_pos;
      anp2_r  <= s1_r.a_now_pos;
      blp2_r  <= s1_r.b_last_pos;
      bnp2_r  <= s1_r.b_now_pos;
      alo2_r  <= SEXT_W'(p_alo_nxt >>> aop_pkg::FRAC_SHIFT);
      ahi2_r  <= SEXT_W'(p_ahi_nxt >>> aop_pkg::FRAC_SHIFT);
      blo2_r  <= SEXT_W'(p_blo_nxt >>> aop_pkg::FRAC_SHIFT);
      bhi2_r  <= SEXT_W'(p_bhi_nxt >>> aop_pkg::FRAC_SHIFT);
    end
    if (rdy3) begin
      ax3_r    <= ax2_r;
      want3_r  <= want2_r;
      alo_l3_r <= BOUND_W'(alp2_r) + BOUND_W'(alo2_r);
      ahi_l3_r <= BOUND_W'(alp2_r) + BOUND_W'(ahi2_r);
      blo_l3_r <= BOUND_W'(blp2_r) + BOUND_W'(blo2_r);
      bhi_l3_r <= BOUND_W'(blp2_r) + BOUND_W'(bhi2_r);
      alo_n3_r <= BOUND_W'(anp2_r) + BOUND_W'(alo2_r);
      ahi_n3_r <= BOUND_W'(anp2_r) + BOUND_W'(ahi2_r);
      blo_n3_r <= BOUND_W'(bnp2_r) + BOUND_W'(blo2_r);
      bhi_n3_r <= BOUND_W'(bnp2_r) + BOUND_W'(bhi2_r);
    end
    if (rdy4) begin
      ax4_r    <= ax3_r;
      want4_r  <= want3_r;
      gd_hi4_r <= DIFF_W'(ahi_l3_r) - DIFF_W'(blo_l3_r);
      gd_lo4_r <= DIFF_W'(bhi_l3_r) - DIFF_W'(alo_l3_r);
      pd_hi4_r <= DIFF_W'(ahi_n3_r) - DIFF_W'(blo_n3_r);
      pd_lo4_r <= DIFF_W'(alo_n3_r) - DIFF_W'(bhi_n3_r);
    end
    if (rdy5) begin
      res5_r <= res5_nxt;
    end
  end

  assign res_valid = v5_r;
  assign res_data  = res5_r;

endmodule

// ----- rtl/aop_pick.sv -----
// Running overlap and minimum-gap side selection, with the result register.
module aop_pick (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  output logic                res_take,
  input  aop_pkg::axis_res_t  res_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aop_pkg::out_item_t  out_data
);

  localparam int GAP_W  = aop_pkg::GAP_W;
  localparam int PUSH_W = aop_pkg::PUSH_W;

  // Test state
  logic                     overlap_r;
  logic [GAP_W-1:0]         best_gap_r;
  aop_pkg::axis_t           best_axis_r;
  logic signed [PUSH_W-1:0] best_push_r;

  logic                     overlap_nxt;
  logic [GAP_W-1:0]         best_gap_nxt;
  aop_pkg::axis_t           best_axis_nxt;
  logic signed [PUSH_W-1:0] best_push_nxt;

  // Result register
  logic               out_valid_r;
  aop_pkg::out_item_t out_data_r;
  aop_pkg::out_item_t out_data_nxt;

  logic out_free;
  logic ends_test;

  assign out_free  = !out_valid_r || !out_stall;
  assign ends_test = (res_data.axis == aop_pkg::AXIS_Z);
  assign res_take  = res_valid && (!ends_test || out_free);

  // Fold this axis into the running overlap and minimum; ties keep the earlier side
  always_comb begin
    if (res_data.axis == aop_pkg::AXIS_X) begin
      overlap_nxt   = res_data.ov;
      best_gap_nxt  = res_data.gap_hi;
      best_axis_nxt = res_data.axis;
      best_push_nxt = res_data.push_hi;
    end else begin
      overlap_nxt   = overlap_r && res_data.ov;
      best_gap_nxt  = best_gap_r;
      best_axis_nxt = best_axis_r;
      best_push_nxt = best_push_r;
      if (res_data.gap_hi < best_gap_r) begin
        best_gap_nxt  = res_data.gap_hi;
        best_axis_nxt = res_data.axis;
        best_push_nxt = res_data.push_hi;
      end
    end
    if (res_data.gap_lo < best_gap_nxt) begin
      best_gap_nxt  = res_data.gap_lo;
      best_axis_nxt = res_data.axis;
      best_push_nxt = res_data.push_lo;
    end
  end

  // Build the result: push only on the winning axis, and only on a wanted hit
  always_comb begin
    out_data_nxt.hit    = overlap_nxt;
    out_data_nxt.push_x = '0;
    out_data_nxt.push_y = '0;
    out_data_nxt.push_z = '0;
    if (overlap_nxt && res_data.want_push) begin
      unique case (best_axis_nxt)
        aop_pkg::AXIS_X: out_data_nxt.push_x = best_push_nxt;
        aop_pkg::AXIS_Y: out_data_nxt.push_y = best_push_nxt;
        aop_pkg::AXIS_Z: out_data_nxt.push_z = best_push_nxt;
        default:         out_data_nxt.push_x = '0;
      endcase
    end
  end

  // Update state on each taken axis item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overlap_r   <= 1'b1;
      best_gap_r  <= '0;
      best_axis_r <= aop_pkg::AXIS_X;
      best_push_r <= '0;
    end else if (res_take) begin
      overlap_r   <= overlap_nxt;
      best_gap_r  <= best_gap_nxt;
      best_axis_r <= best_axis_nxt;
      best_push_r <= best_push_nxt;
    end
  end

  // Load the result on the closing axis; drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take && ends_test) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && ends_test) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/aabb_overlap_push_side_top.sv -----
// Top level of the box overlap test with minimum-gap push-side selection.
//
//   Channel | Dir | Handshake            | Payload
//   in      | in  | in_valid, in_stall   | aop_pkg::in_item_t, one axis per transfer
//   out     | out | out_valid, out_stall | aop_pkg::out_item_t, one per closing z item
//
// One axis item is taken every cycle while in_stall is low; the z item's result passes
// through the input register, extent multipliers, bounds, differences, gaps, then
// the running-minimum stage that loads the result register.
// Reset clears all stage valids and sets the test state to overlap, zero gap, x axis.
// A held result stalls only the last stage; empty stages behind it keep filling, so
// in_stall rises only once every stage is full. Items with no axis are taken and dropped.
module aabb_overlap_push_side_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aop_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aop_pkg::out_item_t out_data
);

  logic               res_valid;
  logic               res_take;
  aop_pkg::axis_res_t res_data;

  // Per-axis arithmetic
  aop_axis_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data)
  );

  // Side selection and result register
  aop_pick u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
